[design/bct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants of the binary contour tracer: item structs,
// mode and heading codes, register indexes and pixel store request types.
// ----------------------------------------------------------------------------
package bct_pkg;

  // default image limits
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // field widths
  localparam int CORNER_W = 9;             // corner and pixel coordinate fields
  localparam int PROBE_W  = CORNER_W + 1;  // probe coordinate, holds x + 1
  localparam int ADDR_EXT_W = 13;          // wide enough for a 4096 limit

  // item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;

  // headings, north decreases y
  localparam logic [1:0] HEAD_N = 2'd0;
  localparam logic [1:0] HEAD_E = 2'd1;
  localparam logic [1:0] HEAD_S = 2'd2;
  localparam logic [1:0] HEAD_W = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]          mode;
    logic [CORNER_W-1:0] pixel_col;
    logic [CORNER_W-1:0] pixel_row;
    logic                pixel_black;
  } in_item_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
    logic                found;
    logic                last;
  } out_item_t;

  // one-based pixel read request
  typedef struct packed {
    logic [PROBE_W-1:0] col;
    logic [PROBE_W-1:0] row;
  } probe_t;

  // one-based pixel write request
  typedef struct packed {
    logic                en;
    logic [CORNER_W-1:0] col;
    logic [CORNER_W-1:0] row;
    logic                black;
  } pix_wr_t;

endpackage

[design/bct_pixel_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_pixel_store
// One-bit image memory with one write and one registered read port. The
// read side checks the requested pixel against the image size in use and
// returns white for anything outside it.
// ----------------------------------------------------------------------------
module bct_pixel_store #(
  parameter int MAX_WIDTH  = bct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bct_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic [bct_pkg::CORNER_W-1:0]  used_w,
  input  logic [bct_pkg::CORNER_W-1:0]  used_h,
  input  bct_pkg::probe_t               probe,
  input  bct_pkg::pix_wr_t              wr,
  output logic                          pixel
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = 1 << (CW + RW);
  localparam int XW    = bct_pkg::ADDR_EXT_W;

  logic                 pix_mem [0:DEPTH-1];
  logic                 q_r;
  logic                 ok_r;
  logic                 rd_ok;
  logic [XW-1:0]        rd_col_ext;
  logic [XW-1:0]        rd_row_ext;
  logic [CW+RW-1:0]     rd_addr;
  logic                 wr_ok;
  logic [XW-1:0]        wr_col_ext;
  logic [XW-1:0]        wr_row_ext;
  logic [CW+RW-1:0]     wr_addr;

  // read side: range check against the size in use, zero-based address
  assign rd_ok = (probe.col != '0) && (probe.col <= {1'b0, used_w}) &&
                 (probe.row != '0) && (probe.row <= {1'b0, used_h});
  assign rd_col_ext = {{(XW-bct_pkg::PROBE_W){1'b0}}, probe.col - 1'b1};
  assign rd_row_ext = {{(XW-bct_pkg::PROBE_W){1'b0}}, probe.row - 1'b1};
  assign rd_addr    = {rd_row_ext[RW-1:0], rd_col_ext[CW-1:0]};

  // write side: loads beyond the store limits are dropped
  assign wr_col_ext = {{(XW-bct_pkg::CORNER_W){1'b0}}, wr.col - 1'b1};
  assign wr_row_ext = {{(XW-bct_pkg::CORNER_W){1'b0}}, wr.row - 1'b1};
  assign wr_ok = (wr.col != '0) &&
                 ({{(XW-bct_pkg::CORNER_W){1'b0}}, wr.col} <= XW'(MAX_WIDTH)) &&
                 (wr.row != '0) &&
                 ({{(XW-bct_pkg::CORNER_W){1'b0}}, wr.row} <= XW'(MAX_HEIGHT));
  assign wr_addr = {wr_row_ext[RW-1:0], wr_col_ext[CW-1:0]};

  // memory write
  always_ff @(posedge clk) begin
    if (wr.en && wr_ok) begin
      pix_mem[wr_addr] <= wr.black;
    end
  end

  // registered read, masked when outside the image
  always_ff @(posedge clk) begin
    q_r  <= pix_mem[rd_addr];
    ok_r <= rd_ok;
  end

  assign pixel = q_r & ok_r;

endmodule

[design/bct_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_ctrl
// Sequencer of the contour tracer. Drives the single pixel probe for the
// row-major start scan and for the two front-pixel reads of each step,
// keeps the walker state and produces the result strobe.
// ----------------------------------------------------------------------------
module bct_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bct_pkg::in_item_t             in_data,
  input  logic [bct_pkg::CORNER_W-1:0]  used_w,
  input  logic [bct_pkg::CORNER_W-1:0]  used_h,
  output bct_pkg::probe_t               probe,
  output bct_pkg::pix_wr_t              wr,
  input  logic                          pixel,
  output logic                          out_valid,
  output bct_pkg::out_item_t            out_data
);

  localparam int CW = bct_pkg::CORNER_W;
  localparam int PW = bct_pkg::PROBE_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_ADV_R = 4'b0100,
    ST_ADV_T = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      walk_x_r, walk_x_nxt;
  logic [CW-1:0]      walk_y_r, walk_y_nxt;
  logic [1:0]         head_r, head_nxt;
  logic [CW-1:0]      start_x_r, start_x_nxt;
  logic [CW-1:0]      start_y_r, start_y_nxt;
  logic               active_r, active_nxt;
  logic [CW-1:0]      scan_c_r, scan_c_nxt;
  logic [CW-1:0]      scan_r_r, scan_r_nxt;
  logic               scan_done_r, scan_done_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [CW-1:0]      pend_c_r, pend_c_nxt;
  logic [CW-1:0]      pend_r_r, pend_r_nxt;
  logic               left_r, left_nxt;
  logic               out_valid_r, out_valid_nxt;
  bct_pkg::out_item_t out_data_r, out_data_nxt;

  logic               accept;
  logic [CW-1:0]      step_x;
  logic [CW-1:0]      step_y;
  logic [1:0]         turn_head;

  // one-based coordinates of the left or right front pixel
  function automatic bct_pkg::probe_t front_pixel(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y,
                                                  input logic [1:0]    h,
                                                  input logic          is_left);
    bct_pkg::probe_t p;
    logic [PW-1:0]   x0;
    logic [PW-1:0]   x1;
    logic [PW-1:0]   y0;
    logic [PW-1:0]   y1;
    x0 = {1'b0, x};
    x1 = {1'b0, x} + 1'b1;
    y0 = {1'b0, y};
    y1 = {1'b0, y} + 1'b1;
    case (h)
      bct_pkg::HEAD_N: begin
        p.col = is_left ? x0 : x1;
        p.row = y0;
      end
      bct_pkg::HEAD_E: begin
        p.col = x1;
        p.row = is_left ? y0 : y1;
      end
      bct_pkg::HEAD_S: begin
        p.col = is_left ? x1 : x0;
        p.row = y1;
      end
      default: begin
        p.col = x0;
        p.row = is_left ? y1 : y0;
      end
    endcase
    return p;
  endfunction

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // walker moved one unit along its heading
  always_comb begin
    step_x = walk_x_r;
    step_y = walk_y_r;
    case (head_r)
      bct_pkg::HEAD_N: step_y = walk_y_r - 1'b1;
      bct_pkg::HEAD_E: step_x = walk_x_r + 1'b1;
      bct_pkg::HEAD_S: step_y = walk_y_r + 1'b1;
      default:         step_x = walk_x_r - 1'b1;
    endcase
  end

  // heading after the step, left pixel registered, right pixel arriving now
  always_comb begin
    if (left_r) begin
      turn_head = head_r + 2'd3;
    end else if (!pixel) begin
      turn_head = head_r + 2'd1;
    end else begin
      turn_head = head_r;
    end
  end

  // shared pixel probe
  always_comb begin
    case (state_r)
      ST_SCAN: begin
        probe.col = {1'b0, scan_c_r};
        probe.row = {1'b0, scan_r_r};
      end
      ST_ADV_R: probe = front_pixel(walk_x_r, walk_y_r, head_r, 1'b0);
      default:  probe = front_pixel(step_x, step_y, head_r, 1'b1);
    endcase
  end

  // pixel loads go straight to the store
  assign wr.en    = accept && (in_data.mode == bct_pkg::MODE_LOAD);
  assign wr.col   = in_data.pixel_col;
  assign wr.row   = in_data.pixel_row;
  assign wr.black = in_data.pixel_black;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    walk_x_nxt    = walk_x_r;
    walk_y_nxt    = walk_y_r;
    head_nxt      = head_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    active_nxt    = active_r;
    scan_c_nxt    = scan_c_r;
    scan_r_nxt    = scan_r_r;
    scan_done_nxt = scan_done_r;
    pend_v_nxt    = pend_v_r;
    pend_c_nxt    = pend_c_r;
    pend_r_nxt    = pend_r_r;
    left_nxt      = left_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.mode == bct_pkg::MODE_START) begin
          scan_c_nxt    = CW'(1);
          scan_r_nxt    = CW'(1);
          scan_done_nxt = 1'b0;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_SCAN;
        end else if (accept && in_data.mode == bct_pkg::MODE_STEP && active_r) begin
          // left read issued this cycle from the stepped position
          walk_x_nxt = step_x;
          walk_y_nxt = step_y;
          state_nxt  = ST_ADV_R;
        end
      end
      ST_SCAN: begin
        // issue the next pixel in row-major order
        if (!scan_done_r) begin
          pend_v_nxt = 1'b1;
          pend_c_nxt = scan_c_r;
          pend_r_nxt = scan_r_r;
          if (scan_c_r == used_w) begin
            scan_c_nxt = CW'(1);
            if (scan_r_r == used_h) begin
              scan_done_nxt = 1'b1;
            end else begin
              scan_r_nxt = scan_r_r + 1'b1;
            end
          end else begin
            scan_c_nxt = scan_c_r + 1'b1;
          end
        end else begin
          pend_v_nxt = 1'b0;
        end
        // check the pixel read in the previous cycle
        if (pend_v_r && pixel) begin
          walk_x_nxt            = pend_c_r - 1'b1;
          walk_y_nxt            = pend_r_r - 1'b1;
          start_x_nxt           = pend_c_r - 1'b1;
          start_y_nxt           = pend_r_r - 1'b1;
          head_nxt              = bct_pkg::HEAD_E;
          active_nxt            = 1'b1;
          out_valid_nxt         = 1'b1;
          out_data_nxt.corner_x = pend_c_r - 1'b1;
          out_data_nxt.corner_y = pend_r_r - 1'b1;
          out_data_nxt.found    = 1'b1;
          out_data_nxt.last     = 1'b0;
          state_nxt             = ST_IDLE;
        end else if (scan_done_r && !pend_v_r) begin
          active_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ADV_R: begin
        left_nxt  = pixel;
        state_nxt = ST_ADV_T;
      end
      ST_ADV_T: begin
        head_nxt              = turn_head;
        out_valid_nxt         = 1'b1;
        out_data_nxt.corner_x = walk_x_r;
        out_data_nxt.corner_y = walk_y_r;
        out_data_nxt.found    = 1'b1;
        out_data_nxt.last     = (walk_x_r == start_x_r) && (walk_y_r == start_y_r) &&
                                (turn_head == bct_pkg::HEAD_E);
        state_nxt             = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_x_r    <= '0;
      walk_y_r    <= '0;
      head_r      <= bct_pkg::HEAD_E;
      start_x_r   <= '0;
      start_y_r   <= '0;
      active_r    <= 1'b0;
      scan_done_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_x_r    <= walk_x_nxt;
      walk_y_r    <= walk_y_nxt;
      head_r      <= head_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      active_r    <= active_nxt;
      scan_done_r <= scan_done_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_c_r   <= scan_c_nxt;
    scan_r_r   <= scan_r_nxt;
    pend_c_r   <= pend_c_nxt;
    pend_r_r   <= pend_r_nxt;
    left_r     <= left_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/binary_contour_tracer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_contour_tracer
// Traces the outer contour of a black-and-white image along pixel corners.
// ----------------------------------------------------------------------------
// Usage:
//   Items go in on in_data and are taken at a clock edge with start high and
//   busy low. Mode load writes one pixel and is done at once (busy stays
//   low). Mode start scans the image row by row for the first black pixel
//   and returns its upper-left corner, or found low for an empty image.
//   Mode advance moves the walker one unit, turns it and returns the new
//   corner; last marks the return to the start corner heading east.
//   Each result is shown for one cycle with out_valid high; the receiver
//   cannot stall, so every result must be taken in that cycle.
//   An advance holds busy while the right front pixel is read and the
//   turn made, so the next advance waits; both front-pixel reads share
//   the image memory's single read port. A start holds busy while it scans,
//   one pixel read per cycle through the same port. The always-ready cfg_
//   channel writes image size (index 0 width, 1 height); the user must
//   write it only while the block is idle, which the block does not check.
//   Reset clears the walker, the trace state and sets the size to 256 x 256;
//   image contents are not cleared and must be loaded before a start.
// ----------------------------------------------------------------------------
module binary_contour_tracer #(
  parameter int MAX_WIDTH  = bct_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bct_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bct_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output bct_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [bct_pkg::CORNER_W-1:0]  cfg_data
);

  localparam int CW = bct_pkg::CORNER_W;
  localparam int XW = bct_pkg::ADDR_EXT_W;

  logic [CW-1:0]    width_r;
  logic [CW-1:0]    height_r;
  logic [CW-1:0]    used_w;
  logic [CW-1:0]    used_h;
  bct_pkg::probe_t  probe;
  bct_pkg::pix_wr_t wr;
  logic             pixel;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CW'(256);
      height_r <= CW'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        bct_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_data;
        bct_pkg::CFG_IDX_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // size in use, saturated to 1..limit
  always_comb begin
    if (width_r == '0) begin
      used_w = CW'(1);
    end else if ({{(XW-CW){1'b0}}, width_r} > XW'(MAX_WIDTH)) begin
      used_w = CW'(MAX_WIDTH);
    end else begin
      used_w = width_r;
    end
    if (height_r == '0) begin
      used_h = CW'(1);
    end else if ({{(XW-CW){1'b0}}, height_r} > XW'(MAX_HEIGHT)) begin
      used_h = CW'(MAX_HEIGHT);
    end else begin
      used_h = height_r;
    end
  end

  bct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .used_w    (used_w),
    .used_h    (used_h),
    .probe     (probe),
    .wr        (wr),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  bct_pixel_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk    (clk),
    .used_w (used_w),
    .used_h (used_h),
    .probe  (probe),
    .wr     (wr),
    .pixel  (pixel)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_contour_tracer. Images of mostly small size
// are loaded pixel by pixel, then traced with start and advance commands
// until the contour closes and a little beyond. A behavioral tracer in the
// bench predicts every corner; results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bct_pkg::*;

  // codes the package does not name
  localparam logic [1:0] MODE_NONE       = 2'd3;
  localparam logic [1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_IDX_SPARE_B = 2'd3;

  // image pattern kinds
  localparam int IMG_BLANK   = 0;
  localparam int IMG_RECT    = 1;
  localparam int IMG_SPECKLE = 2;

  localparam int IMG_MAX     = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_MAX  = 10;
  localparam int ITEM_GOAL   = 1350;
  localparam int STEP_CAP    = 1200;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_item_t            in_data   = '0;
  logic                out_valid;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [CORNER_W-1:0] cfg_data  = '0;

  binary_contour_tracer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // tracer state kept by the bench
  bit                  pix_img [0:IMG_MAX*IMG_MAX-1];
  logic [CORNER_W-1:0] area_w_reg  = 9'd256;
  logic [CORNER_W-1:0] area_h_reg  = 9'd256;
  logic [CORNER_W-1:0] walk_x      = '0;
  logic [CORNER_W-1:0] walk_y      = '0;
  logic [CORNER_W-1:0] anchor_x    = '0;
  logic [CORNER_W-1:0] anchor_y    = '0;
  logic [1:0]          heading     = HEAD_E;
  bit                  trace_on    = 1'b0;
  bit                  loop_closed = 1'b0;

  out_item_t corner_q [$];
  in_item_t  item_q [$];

  int items_made     = 0;
  int gap_left       = 0;
  bit no_gaps        = 1'b0;
  int mismatch_count = 0;
  int stall_cycles   = 0;

  function automatic int used_w();
    if (area_w_reg == 0) return 1;
    if (area_w_reg > IMG_MAX) return IMG_MAX;
    return int'(area_w_reg);
  endfunction

  function automatic int used_h();
    if (area_h_reg == 0) return 1;
    if (area_h_reg > IMG_MAX) return IMG_MAX;
    return int'(area_h_reg);
  endfunction

  // one-based pixel, white outside the area in use
  function automatic bit pix_read(int col, int row);
    if (col < 1 || col > used_w() || row < 1 || row > used_h()) return 1'b0;
    return pix_img[(col - 1) + (row - 1) * IMG_MAX];
  endfunction

  // apply one accepted command and queue the corner it should produce
  function automatic void predict_corner(in_item_t it);
    int        c, r, lx, ly;
    bit        lft, rgt, hit;
    out_item_t res;
    res = '0;
    case (it.mode)
      MODE_LOAD: begin
        if (it.pixel_col >= 1 && it.pixel_col <= IMG_MAX &&
            it.pixel_row >= 1 && it.pixel_row <= IMG_MAX)
          pix_img[(it.pixel_col - 1) + (it.pixel_row - 1) * IMG_MAX] = it.pixel_black;
      end
      MODE_START: begin
        hit = 1'b0;
        for (r = 1; r <= used_h() && !hit; r++) begin
          for (c = 1; c <= used_w() && !hit; c++) begin
            if (pix_read(c, r)) begin
              hit      = 1'b1;
              walk_x   = CORNER_W'(c - 1);
              walk_y   = CORNER_W'(r - 1);
              anchor_x = CORNER_W'(c - 1);
              anchor_y = CORNER_W'(r - 1);
            end
          end
        end
        trace_on    = hit;
        loop_closed = 1'b0;
        if (hit) begin
          heading      = HEAD_E;
          res.corner_x = walk_x;
          res.corner_y = walk_y;
          res.found    = 1'b1;
        end
        corner_q.push_back(res);
      end
      MODE_STEP: begin
        if (trace_on) begin
          // move one unit, corners wrap in 9 bits
          case (heading)
            HEAD_N:  walk_y = walk_y - 1'b1;
            HEAD_E:  walk_x = walk_x + 1'b1;
            HEAD_S:  walk_y = walk_y + 1'b1;
            default: walk_x = walk_x - 1'b1;
          endcase
          lx = int'(walk_x);
          ly = int'(walk_y);
          // front-left and front-right pixels
          case (heading)
            HEAD_N: begin
              lft = pix_read(lx, ly);
              rgt = pix_read(lx + 1, ly);
            end
            HEAD_E: begin
              lft = pix_read(lx + 1, ly);
              rgt = pix_read(lx + 1, ly + 1);
            end
            HEAD_S: begin
              lft = pix_read(lx + 1, ly + 1);
              rgt = pix_read(lx, ly + 1);
            end
            default: begin
              lft = pix_read(lx, ly + 1);
              rgt = pix_read(lx, ly);
            end
          endcase
          if (lft) heading = heading + 2'd3;
          else if (!rgt) heading = heading + 2'd1;
          res.corner_x = walk_x;
          res.corner_y = walk_y;
          res.found    = 1'b1;
          res.last     = (walk_x == anchor_x && walk_y == anchor_y && heading == HEAD_E);
          if (res.last) loop_closed = 1'b1;
          corner_q.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return ($urandom_range(0, 1) != 0) ? 0 : int'($urandom_range(1, 16));
  endfunction

  // command driver
  always @(posedge clk) begin : feed
    int wait_n;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_corner(in_data);
        wait_n = draw_gap();
        if (wait_n == 0 && item_q.size() != 0) begin
          in_data <= item_q.pop_front();
        end else begin
          start    <= 1'b0;
          gap_left <= wait_n;
        end
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (item_q.size() != 0) begin
          start   <= 1'b1;
          in_data <= item_q.pop_front();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst_n && out_valid) begin
      if (corner_q.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected corner x=%0d y=%0d found=%0b last=%0b at %0t",
                   out_data.corner_x, out_data.corner_y, out_data.found,
                   out_data.last, $realtime);
      end else begin
        want = corner_q.pop_front();
        if (out_data.corner_x !== want.corner_x || out_data.corner_y !== want.corner_y ||
            out_data.found !== want.found || out_data.last !== want.last) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_MAX)
            $display("corner mismatch at %0t: exp x=%0d y=%0d found=%0b last=%0b, got x=%0d y=%0d found=%0b last=%0b",
                     $realtime, want.corner_x, want.corner_y, want.found, want.last,
                     out_data.corner_x, out_data.corner_y, out_data.found, out_data.last);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic void queue_item(logic [1:0] mode, int col, int row, bit black);
    in_item_t it;
    it.mode        = mode;
    it.pixel_col   = CORNER_W'(col);
    it.pixel_row   = CORNER_W'(row);
    it.pixel_black = black;
    item_q.push_back(it);
    items_made++;
  endfunction

  // command with random filler in the pixel fields
  function automatic void queue_cmd(logic [1:0] mode);
    queue_item(mode, $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1));
  endfunction

  // wait until every command went in and every corner came back
  task automatic drain();
    do @(negedge clk);
    while (item_q.size() != 0 || start || corner_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CORNER_W'(val);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_WIDTH) area_w_reg = CORNER_W'(val);
    else if (idx == CFG_IDX_HEIGHT) area_h_reg = CORNER_W'(val);
    @(negedge clk);
  endtask

  // write every pixel of the area in random order, with noise mixed in
  task automatic load_area(input int kind, input bit walker_idle);
    int w, h, k, j, tmp, c, r, c0, c1, r0, r1, density;
    bit black;
    int order [$];
    w       = used_w();
    h       = used_h();
    c0      = $urandom_range(1, w);
    c1      = $urandom_range(c0, w);
    r0      = $urandom_range(1, h);
    r1      = $urandom_range(r0, h);
    density = $urandom_range(15, 85);
    for (k = 0; k < w * h; k++) order.push_back(k);
    for (k = w * h - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      c = order[k] % w + 1;
      r = order[k] / w + 1;
      case (kind)
        IMG_RECT:    black = (c >= c0 && c <= c1 && r >= r0 && r <= r1);
        IMG_SPECKLE: black = ($urandom_range(0, 99) < density);
        default:     black = 1'b0;
      endcase
      queue_item(MODE_LOAD, c, r, black);
      // noise: stray loads, unused mode, advances while no trace runs
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0:       queue_cmd(MODE_LOAD);
          1:       queue_cmd(MODE_NONE);
          default: if (walker_idle) queue_cmd(MODE_STEP);
        endcase
      end
    end
  endtask

  // one image: size, load, start, walk until closed, then a few more steps
  task automatic run_phase(input int wreg, input int hreg, input int kind);
    int steps, n, k;
    drain();
    no_gaps = ($urandom_range(0, 3) == 0);
    if (wreg >= 0) write_reg(CFG_IDX_WIDTH, wreg);
    if (hreg >= 0) write_reg(CFG_IDX_HEIGHT, hreg);
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                $urandom_range(0, 511));
    load_area(kind, !trace_on);
    queue_cmd(MODE_START);
    drain();
    steps = 0;
    while (trace_on && !loop_closed && steps < STEP_CAP) begin
      n = $urandom_range(4, 24);
      for (k = 0; k < n; k++) begin
        // rare pixel change in the middle of a trace
        if ($urandom_range(0, 40) == 0)
          queue_item(MODE_LOAD, $urandom_range(1, used_w()), $urandom_range(1, used_h()),
                     $urandom_range(0, 1));
        queue_cmd(MODE_STEP);
      end
      steps += n;
      drain();
    end
    // retrace after close, or steps ignored with no trace
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) queue_cmd(MODE_STEP);
  endtask

  initial begin : stimulus
    int w, h, kind, pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // advance with no trace, unused mode, loads off and at the edge of the image
    queue_item(MODE_STEP, 0, 0, 1'b0);
    queue_item(MODE_NONE, 511, 511, 1'b1);
    queue_item(MODE_LOAD, 0, 1, 1'b1);
    queue_item(MODE_LOAD, 257, 1, 1'b1);
    queue_item(MODE_LOAD, 1, 0, 1'b1);
    queue_item(MODE_LOAD, 511, 511, 1'b1);
    queue_item(MODE_LOAD, 256, 256, 1'b1);
    queue_item(MODE_LOAD, 256, 1, 1'b0);
    drain();

    // 2 x 2 image: empty start, then a single black pixel traced round
    write_reg(CFG_IDX_WIDTH, 2);
    write_reg(CFG_IDX_HEIGHT, 2);
    queue_item(MODE_LOAD, 1, 1, 1'b0);
    queue_item(MODE_LOAD, 2, 1, 1'b0);
    queue_item(MODE_LOAD, 1, 2, 1'b0);
    queue_item(MODE_LOAD, 2, 2, 1'b0);
    queue_item(MODE_START, 0, 0, 1'b0);
    queue_item(MODE_STEP, 0, 0, 1'b0);
    queue_item(MODE_LOAD, 2, 2, 1'b1);
    queue_item(MODE_START, 0, 0, 1'b0);
    repeat (5) queue_item(MODE_STEP, 0, 0, 1'b0);

    // size extremes, saturating register values among them
    run_phase(511, 1, IMG_SPECKLE);
    run_phase(0, 256, IMG_SPECKLE);
    run_phase(1, 1, IMG_RECT);

    // random images, mostly small
    while (items_made < ITEM_GOAL) begin
      w    = $urandom_range(1, 12);
      h    = $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      kind = (pick == 0) ? IMG_BLANK : (pick <= 3) ? IMG_RECT : IMG_SPECKLE;
      if ($urandom_range(0, 5) == 0 && used_w() <= 16) w = -1;
      if ($urandom_range(0, 5) == 0 && used_h() <= 16) h = -1;
      run_phase(w, h, kind);
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
design/bct_pkg.sv
design/bct_pixel_store.sv
design/bct_ctrl.sv
design/binary_contour_tracer.sv
tb/tb_top.sv
